FILE: src/nrcl_pkg.sv
// shared types and constants for the nearest ray crossing line block
package nrcl_pkg;

	localparam int MAX_LINES_DEF  = 1024;
	localparam int COORD_BITS_DEF = 16;

	localparam logic        MODE_WRITE = 1'b0;
	localparam logic        MODE_QUERY = 1'b1;
	localparam logic [15:0] NO_SECTOR  = 16'hFFFF;

	typedef struct packed {
		logic               mode;
		logic [9:0]         line_index;
		logic signed [15:0] start_x;
		logic signed [15:0] start_y;
		logic signed [15:0] end_x;
		logic signed [15:0] end_y;
		logic [15:0]        right_sector;
		logic [15:0]        left_sector;
		logic signed [15:0] point_x;
		logic signed [15:0] point_y;
	} in_item_t;

	typedef struct packed {
		logic        found;
		logic [9:0]  best_line;
		logic        side_is_left;
		logic        sector_found;
		logic [15:0] sector_index;
	} out_item_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

endpackage

FILE: src/nrcl_dist_cell.sv
// distance pipeline: straddle test, weights, products and exact crossing fraction per line
module nrcl_dist_cell #(
	parameter int CB = nrcl_pkg::COORD_BITS_DEF,
	parameter int AW = 10
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                v_in,
	input  logic [AW-1:0]       idx_in,
	input  logic signed [CB-1:0] x1,
	input  logic signed [CB-1:0] y1,
	input  logic signed [CB-1:0] x2,
	input  logic signed [CB-1:0] y2,
	input  logic signed [CB-1:0] px,
	input  logic signed [CB-1:0] py,
	input  logic [15:0]         rs_in,
	input  logic [15:0]         ls_in,
	output logic                v_out,
	output logic                qual_out,
	output logic [2*CB+1:0]     mag_out,
	output logic [CB:0]         d_out,
	output logic                left_out,
	output logic [AW-1:0]       idx_out,
	output logic [15:0]         rs_out,
	output logic [15:0]         ls_out,
	output logic                busy
);
	import nrcl_pkg::*;

	localparam int MW = 2 * CB + 2;

	logic signed [CB:0] x1e, y1e, x2e, y2e, pxe, pye;
	logic signed [CB:0] dx1, dx2, wad, wbd;
	logic               up1, up2;

	// stage 2
	logic            v_s2, desc_s2, na_s2, nb_s2;
	logic [CB:0]     a1_s2, a2_s2;
	logic [CB-1:0]   wa_s2, wb_s2;
	logic [AW-1:0]   idx_s2;
	logic [15:0]     rs_s2, ls_s2;
	// stage 3
	logic            v_s3, desc_s3, na_s3, nb_s3;
	logic [MW-2:0]   ma_s3, mb_s3;
	logic [CB:0]     d_s3;
	logic [AW-1:0]   idx_s3;
	logic [15:0]     rs_s3, ls_s3;
	// stage 4
	logic            v_s4, qual_s4, left_s4;
	logic [MW-1:0]   mag_s4;
	logic [CB:0]     d_s4;
	logic [AW-1:0]   idx_s4;
	logic [15:0]     rs_s4, ls_s4;

	logic [MW-1:0]   mag_c, ma_e, mb_e;
	logic            neg_c;
	logic [MW+3:0]   mag10;

	always_comb begin
		x1e = x1;
		y1e = y1;
		x2e = x2;
		y2e = y2;
		pxe = px;
		pye = py;
		up1 = y1 > py;
		up2 = y2 > py;
		dx1 = x1e - pxe;
		dx2 = x2e - pxe;
		if (up2) begin
			wad = y2e - pye;
			wbd = pye - y1e;
		end else begin
			wad = pye - y2e;
			wbd = y1e - pye;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_in && (up1 != up2);
		end
	end

	always_ff @(posedge clk) begin
		wa_s2   <= wad[CB-1:0];
		wb_s2   <= wbd[CB-1:0];
		na_s2   <= dx1[CB];
		nb_s2   <= dx2[CB];
		a1_s2   <= dx1[CB] ? (CB+1)'(-dx1) : (CB+1)'(dx1);
		a2_s2   <= dx2[CB] ? (CB+1)'(-dx2) : (CB+1)'(dx2);
		desc_s2 <= y1 > y2;
		idx_s2  <= idx_in;
		rs_s2   <= rs_in;
		ls_s2   <= ls_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		ma_s3   <= (MW-1)'(a1_s2) * (MW-1)'(wa_s2);
		mb_s3   <= (MW-1)'(a2_s2) * (MW-1)'(wb_s2);
		d_s3    <= (CB+1)'(wa_s2) + (CB+1)'(wb_s2);
		na_s3   <= na_s2;
		nb_s3   <= nb_s2;
		desc_s3 <= desc_s2;
		idx_s3  <= idx_s2;
		rs_s3   <= rs_s2;
		ls_s3   <= ls_s2;
	end

	// signed sum of the two weighted terms as magnitude and sign
	always_comb begin
		ma_e = MW'(ma_s3);
		mb_e = MW'(mb_s3);
		if (na_s3 == nb_s3) begin
			mag_c = ma_e + mb_e;
			neg_c = na_s3;
		end else if (ma_e >= mb_e) begin
			mag_c = ma_e - mb_e;
			neg_c = na_s3;
		end else begin
			mag_c = mb_e - ma_e;
			neg_c = nb_s3;
		end
		if (mag_c == '0) begin
			neg_c = 1'b0;
		end
		mag10 = ((MW+4)'(mag_c) << 3) + ((MW+4)'(mag_c) << 1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else begin
			v_s4 <= v_s3;
		end
	end

	// distance above a tenth: 10 * mag > d
	always_ff @(posedge clk) begin
		mag_s4  <= mag_c;
		d_s4    <= d_s3;
		qual_s4 <= mag10 > (MW+4)'(d_s3);
		left_s4 <= desc_s3 == neg_c;
		idx_s4  <= idx_s3;
		rs_s4   <= rs_s3;
		ls_s4   <= ls_s3;
	end

	assign v_out    = v_s4;
	assign qual_out = qual_s4;
	assign mag_out  = mag_s4;
	assign d_out    = d_s4;
	assign left_out = left_s4;
	assign idx_out  = idx_s4;
	assign rs_out   = rs_s4;
	assign ls_out   = ls_s4;
	assign busy     = v_s2 || v_s3 || v_s4;

endmodule

FILE: src/nrcl_best_cell.sv
// running minimum of crossing distances by exact cross multiplication
module nrcl_best_cell #(
	parameter int CB = nrcl_pkg::COORD_BITS_DEF,
	parameter int AW = 10
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              v_in,
	input  logic              qual_in,
	input  logic [2*CB+1:0]   mag_in,
	input  logic [CB:0]       d_in,
	input  logic              left_in,
	input  logic [AW-1:0]     idx_in,
	input  logic [15:0]       rs_in,
	input  logic [15:0]       ls_in,
	output logic              found,
	output logic [AW-1:0]     best_idx,
	output logic              best_left,
	output logic [15:0]       best_rs,
	output logic [15:0]       best_ls,
	output logic              busy
);
	import nrcl_pkg::*;

	localparam int MW = 2 * CB + 2;
	localparam int DW = CB + 1;
	localparam int PW = MW + DW;

	logic            v_s5, left_s5;
	logic [MW-1:0]   mag_s5;
	logic [DW-1:0]   d_s5;
	logic [AW-1:0]   idx_s5;
	logic [15:0]     rs_s5, ls_s5;
	logic [PW-1:0]   pb1_s5, pb2_s5, pp1_s5, pp2_s5;

	logic            found_q, took_q, left_q;
	logic [MW-1:0]   best_n_q;
	logic [DW-1:0]   best_d_q;
	logic [AW-1:0]   idx_q;
	logic [15:0]     rs_q, ls_q;

	logic            lt, take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else begin
			v_s5 <= v_in && qual_in;
		end
	end

	// compare against the stored best and against the line now deciding
	always_ff @(posedge clk) begin
		pb1_s5  <= PW'(mag_in) * PW'(best_d_q);
		pb2_s5  <= PW'(best_n_q) * PW'(d_in);
		pp1_s5  <= PW'(mag_in) * PW'(d_s5);
		pp2_s5  <= PW'(mag_s5) * PW'(d_in);
		mag_s5  <= mag_in;
		d_s5    <= d_in;
		left_s5 <= left_in;
		idx_s5  <= idx_in;
		rs_s5   <= rs_in;
		ls_s5   <= ls_in;
	end

	// when the previous line just won, it is the best the products must use
	always_comb begin
		lt   = took_q ? (pp1_s5 < pp2_s5) : (pb1_s5 < pb2_s5);
		take = v_s5 && (!found_q || lt);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
			took_q  <= 1'b0;
		end else if (start) begin
			found_q <= 1'b0;
			took_q  <= 1'b0;
		end else begin
			took_q <= take;
			if (take) begin
				found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			best_n_q <= mag_s5;
			best_d_q <= d_s5;
			left_q   <= left_s5;
			idx_q    <= idx_s5;
			rs_q     <= rs_s5;
			ls_q     <= ls_s5;
		end
	end

	assign found     = found_q;
	assign best_idx  = idx_q;
	assign best_left = left_q;
	assign best_rs   = rs_q;
	assign best_ls   = ls_q;
	assign busy      = v_s5;

endmodule

FILE: src/nearest_ray_crossing_line.sv
// top level: line table, scan control and result register
//
// Finds the nearest line crossed by a horizontal ray from a query point.
// Input channel (in_valid / in_stall / in_data): mode 0 stores one line
// entry in the table and gives no result; mode 1 is a point query that
// gives exactly one result item on the output channel.
// Config: cfg_we with cfg_data writes line_count, the number of entries
// scanned; write it only while the block is idle.
// A query reads one table entry per cycle through the single read port of
// the line memory and a six-stage chain (read, weights, products, fraction,
// compare, select). With L the smaller of line_count and MAX_LINES, its
// result is loaded once all L entries are read and the chain has drained,
// later when one of the last lines straddles the point and so runs the
// whole chain.
// in_stall stays high while a query runs; one query is in flight at a time.
// A finished result sits in the output register until its transfer; the
// next item is accepted meanwhile, and a new result waits for the register.
// Reset clears line_count and all control state; table entries are
// undefined until written.
module nearest_ray_crossing_line #(
	parameter int MAX_LINES  = nrcl_pkg::MAX_LINES_DEF,
	parameter int COORD_BITS = nrcl_pkg::COORD_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  nrcl_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output nrcl_pkg::out_item_t out_data,
	input  logic                cfg_we,
	input  logic [10:0]         cfg_data
);
	import nrcl_pkg::*;

	localparam int CB = COORD_BITS;
	localparam int AW = $clog2(MAX_LINES);
	localparam int CW = $clog2(MAX_LINES + 1);
	localparam int EW = 4 * CB + 32;

	logic [EW-1:0] mem [MAX_LINES];
	logic [EW-1:0] rd_q;
	logic          rd_v_q;
	logic [AW-1:0] rd_idx_q;

	state_t          state_q, state_d;
	logic [CW-1:0]   cnt_q, limit_q;
	logic [10:0]     line_count_q;
	logic signed [CB-1:0] px_q, py_q;
	out_item_t       out_q;
	logic            out_v_q;

	logic            in_xfer, start, issue, load, pipe_busy;
	logic [31:0]     in_idx_w;
	logic [CW-1:0]   limit_c;

	logic            dv, dqual, dleft, dbusy, bbusy;
	logic [2*CB+1:0] dmag;
	logic [CB:0]     dd;
	logic [AW-1:0]   didx, bidx;
	logic [15:0]     drs, dls, brs, bls, sec;
	logic            bfound, bleft;

	assign in_stall = state_q != ST_IDLE;
	assign in_xfer  = in_valid && !in_stall;
	assign start    = in_xfer && in_data.mode == MODE_QUERY;
	assign in_idx_w = 32'(in_data.line_index);
	assign limit_c  = (32'(line_count_q) < 32'(MAX_LINES)) ? CW'(line_count_q) : CW'(MAX_LINES);
	assign issue    = state_q == ST_SCAN && cnt_q != limit_q;
	assign pipe_busy = rd_v_q || dbusy || bbusy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_count_q <= '0;
		end else if (cfg_we) begin
			line_count_q <= cfg_data;
		end
	end

	// coordinates held at COORD_BITS, sign taken from that width
	always_ff @(posedge clk) begin
		if (in_xfer && in_data.mode == MODE_WRITE && in_idx_w < 32'(MAX_LINES)) begin
			mem[AW'(in_idx_w)] <= {CB'(32'(unsigned'(in_data.start_x))),
				CB'(32'(unsigned'(in_data.start_y))),
				CB'(32'(unsigned'(in_data.end_x))),
				CB'(32'(unsigned'(in_data.end_y))),
				in_data.right_sector, in_data.left_sector};
		end
		if (issue) begin
			rd_q <= mem[cnt_q[AW-1:0]];
		end
		rd_idx_q <= cnt_q[AW-1:0];
		if (start) begin
			px_q    <= CB'(32'(unsigned'(in_data.point_x)));
			py_q    <= CB'(32'(unsigned'(in_data.point_y)));
			limit_q <= limit_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			rd_v_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			rd_v_q  <= issue;
			if (start) begin
				cnt_q <= '0;
			end else if (issue) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		load    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (cnt_q == limit_q && !pipe_busy) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_v_q || !out_stall) begin
					load    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	nrcl_dist_cell #(.CB(CB), .AW(AW)) u_dist (
		.clk      (clk),
		.arst_n   (arst_n),
		.v_in     (rd_v_q),
		.idx_in   (rd_idx_q),
		.x1       (rd_q[4*CB+31 -: CB]),
		.y1       (rd_q[3*CB+31 -: CB]),
		.x2       (rd_q[2*CB+31 -: CB]),
		.y2       (rd_q[CB+31 -: CB]),
		.px       (px_q),
		.py       (py_q),
		.rs_in    (rd_q[31:16]),
		.ls_in    (rd_q[15:0]),
		.v_out    (dv),
		.qual_out (dqual),
		.mag_out  (dmag),
		.d_out    (dd),
		.left_out (dleft),
		.idx_out  (didx),
		.rs_out   (drs),
		.ls_out   (dls),
		.busy     (dbusy)
	);

	nrcl_best_cell #(.CB(CB), .AW(AW)) u_best (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.v_in      (dv),
		.qual_in   (dqual),
		.mag_in    (dmag),
		.d_in      (dd),
		.left_in   (dleft),
		.idx_in    (didx),
		.rs_in     (drs),
		.ls_in     (dls),
		.found     (bfound),
		.best_idx  (bidx),
		.best_left (bleft),
		.best_rs   (brs),
		.best_ls   (bls),
		.busy      (bbusy)
	);

	assign sec = bleft ? bls : brs;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (load) begin
			out_v_q <= 1'b1;
		end else if (!out_stall) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q.found        <= bfound;
			out_q.best_line    <= bfound ? 10'(bidx) : '0;
			out_q.side_is_left <= bfound && bleft;
			out_q.sector_found <= bfound && sec != NO_SECTOR;
			out_q.sector_index <= (bfound && sec != NO_SECTOR) ? sec : '0;
		end
	end

	assign out_valid = out_v_q;
	assign out_data  = out_q;

`ifndef SYNTHESIS
	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ST_DONE))
		else $error("result appeared without a finished scan");
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> cnt_q <= limit_q)
		else $error("scan counter passed the limit");
	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.found |-> out_data.best_line == 10'd0
			&& !out_data.side_is_left && !out_data.sector_found)
		else $error("not-found result carries nonzero fields");
	a_no_sector: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.sector_found |-> out_data.sector_index == 16'd0)
		else $error("sector index without sector");
	a_idle_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE |-> !pipe_busy)
		else $error("result loaded with lines still in flight");
`endif

endmodule

FILE: tb/tb_top.sv
// self-checking testbench for nearest_ray_crossing_line: random line tables and point queries
`timescale 1ns / 1ps

module tb_top;
	import nrcl_pkg::*;

	localparam int TABLE_DEPTH = 1024;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int RX_HOLD_CYCLES = 3000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	in_item_t    in_data = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	out_item_t   out_data;
	logic        cfg_we = 1'b0;
	logic [10:0] cfg_data = '0;

	nearest_ray_crossing_line DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// predictor state
	logic signed [15:0] tab_sx [TABLE_DEPTH];
	logic signed [15:0] tab_sy [TABLE_DEPTH];
	logic signed [15:0] tab_ex [TABLE_DEPTH];
	logic signed [15:0] tab_ey [TABLE_DEPTH];
	logic [15:0]        tab_rs [TABLE_DEPTH];
	logic [15:0]        tab_ls [TABLE_DEPTH];
	logic [10:0]        scan_count = '0;

	in_item_t  item_q[$];
	out_item_t crossing_q[$];
	int        errors = 0;
	int unsigned cyc = 0;
	bit        rx_hold_req = 1'b0;
	bit        rx_hold_done = 1'b0;
	int        rx_hold_left = 0;
	int        stuck_cycles = 0;

	// testbench-side bookkeeping of which entries hold data
	bit written [TABLE_DEPTH];

	function automatic out_item_t nearest_crossing(logic signed [15:0] px16,
			logic signed [15:0] py16);
		out_item_t r;
		longint px, py, x1, y1, x2, y2, dx1, dx2;
		longint unsigned wa, wb, d, ma, mb, mag, best_n, best_d;
		bit [127:0] p1, p2;
		bit na, nb, neg, left, found, best_left;
		int lim, best_idx;
		logic [15:0] sec;
		px = px16;
		py = py16;
		found = 0;
		best_left = 0;
		best_idx = 0;
		best_n = 0;
		best_d = 1;
		lim = (scan_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(scan_count);
		for (int n = 0; n < lim; n++) begin
			x1 = tab_sx[n];
			y1 = tab_sy[n];
			x2 = tab_ex[n];
			y2 = tab_ey[n];
			if ((y1 > py) == (y2 > py))
				continue;
			if (y2 > py) begin
				wa = y2 - py;
				wb = py - y1;
			end else begin
				wa = py - y2;
				wb = y1 - py;
			end
			d = wa + wb;
			dx1 = x1 - px;
			dx2 = x2 - px;
			na = dx1 < 0;
			nb = dx2 < 0;
			ma = longint'(na ? -dx1 : dx1) * wa;
			mb = longint'(nb ? -dx2 : dx2) * wb;
			if (na == nb) begin
				mag = ma + mb;
				neg = na;
			end else if (ma >= mb) begin
				mag = ma - mb;
				neg = na;
			end else begin
				mag = mb - ma;
				neg = nb;
			end
			if (mag == 0)
				neg = 0;
			if (mag <= d / 10)
				continue;
			if (found) begin
				p1 = 128'(mag) * 128'(best_d);
				p2 = 128'(best_n) * 128'(d);
				if (!(p1 < p2))
					continue;
			end
			left = !((y1 > y2) == !neg);
			found = 1;
			best_idx = n;
			best_n = mag;
			best_d = d;
			best_left = left;
		end
		r = '0;
		if (found) begin
			sec = best_left ? tab_ls[best_idx] : tab_rs[best_idx];
			r.found = 1'b1;
			r.best_line = best_idx[9:0];
			r.side_is_left = best_left;
			r.sector_found = (sec != NO_SECTOR);
			r.sector_index = (sec != NO_SECTOR) ? sec : 16'd0;
		end
		return r;
	endfunction

	// the bench idles both sides at random, except in a calm window of each period
	function automatic bit idle_now();
		return ((cyc % 5000) >= 1200) && ($urandom_range(0, 99) < 28);
	endfunction

	always @(posedge clk)
		cyc <= cyc + 1;

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || !in_stall) begin
			if (in_valid) begin
				if (in_data.mode == MODE_QUERY) begin
					crossing_q.insert(crossing_q.size(),
						nearest_crossing(in_data.point_x, in_data.point_y));
				end else begin
					tab_sx[in_data.line_index] = in_data.start_x;
					tab_sy[in_data.line_index] = in_data.start_y;
					tab_ex[in_data.line_index] = in_data.end_x;
					tab_ey[in_data.line_index] = in_data.end_y;
					tab_rs[in_data.line_index] = in_data.right_sector;
					tab_ls[in_data.line_index] = in_data.left_sector;
				end
			end
			if (item_q.size() > 0 && !idle_now()) begin
				in_valid <= 1'b1;
				in_data <= item_q.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// monitor and receiver stall
	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (crossing_q.size() == 0) begin
					$display("%0t: result transfer with nothing expected: %p", $time, out_data);
					errors++;
				end else begin
					want = crossing_q.pop_front();
					if (out_data.found !== want.found) begin
						$display("%0t: found exp %0d got %0d", $time, want.found, out_data.found);
						errors++;
					end
					if (out_data.best_line !== want.best_line) begin
						$display("%0t: best_line exp %0d got %0d", $time, want.best_line,
							out_data.best_line);
						errors++;
					end
					if (out_data.side_is_left !== want.side_is_left) begin
						$display("%0t: side_is_left exp %0d got %0d", $time, want.side_is_left,
							out_data.side_is_left);
						errors++;
					end
					if (out_data.sector_found !== want.sector_found) begin
						$display("%0t: sector_found exp %0d got %0d", $time, want.sector_found,
							out_data.sector_found);
						errors++;
					end
					if (out_data.sector_index !== want.sector_index) begin
						$display("%0t: sector_index exp %0d got %0d", $time, want.sector_index,
							out_data.sector_index);
						errors++;
					end
				end
			end
			if (rx_hold_req && !rx_hold_done) begin
				rx_hold_done <= 1'b1;
				rx_hold_left <= RX_HOLD_CYCLES;
				out_stall <= 1'b1;
			end else if (rx_hold_left > 0) begin
				rx_hold_left <= rx_hold_left - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= idle_now();
			end
		end
	end

	// watchdog on cycles with no transfer on either channel
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || !arst_n)
			stuck_cycles <= 0;
		else
			stuck_cycles <= stuck_cycles + 1;
		if (stuck_cycles == WATCHDOG_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	function automatic logic [15:0] rand_coord();
		case ($urandom_range(0, 9))
			0: begin
				case ($urandom_range(0, 3))
					0: return 16'h8000;
					1: return 16'h7fff;
					2: return 16'h0000;
					default: return 16'hffff;
				endcase
			end
			1, 2: return 16'($urandom);
			default: return 16'($urandom_range(0, 128) - 64);
		endcase
	endfunction

	function automatic logic [15:0] rand_sector();
		return ($urandom_range(0, 9) == 0) ? NO_SECTOR : 16'($urandom);
	endfunction

	function automatic in_item_t line_item(int idx, int sx, int sy, int ex, int ey,
			logic [15:0] rs, logic [15:0] ls);
		in_item_t it;
		it = in_item_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
		it.mode = MODE_WRITE;
		it.line_index = idx[9:0];
		it.start_x = sx[15:0];
		it.start_y = sy[15:0];
		it.end_x = ex[15:0];
		it.end_y = ey[15:0];
		it.right_sector = rs;
		it.left_sector = ls;
		return it;
	endfunction

	function automatic in_item_t query_item(int px, int py);
		in_item_t it;
		it = in_item_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
		it.mode = MODE_QUERY;
		it.point_x = px[15:0];
		it.point_y = py[15:0];
		return it;
	endfunction

	// append one item to the pending queue of the driver
	task automatic add_item(in_item_t it);
		item_q.insert(item_q.size(), it);
	endtask

	task automatic push_line(int idx);
		written[idx] = 1;
		add_item(line_item(idx, int'(signed'(rand_coord())), int'(signed'(rand_coord())),
			int'(signed'(rand_coord())), int'(signed'(rand_coord())), rand_sector(),
			rand_sector()));
	endtask

	// query aimed between the y ends of the newest queued line in the scanned range; some are random points
	task automatic push_query(int cnt);
		in_item_t ln;
		int lo, hi, py;
		if (cnt == 0 || $urandom_range(0, 9) < 3) begin
			add_item(query_item(int'(signed'(rand_coord())), int'(signed'(rand_coord()))));
			return;
		end
		ln = '0;
		for (int k = item_q.size() - 1; k >= 0; k--) begin
			if (item_q[k].mode == MODE_WRITE && item_q[k].line_index < cnt) begin
				ln = item_q[k];
				break;
			end
		end
		if (ln.start_y == ln.end_y) begin
			add_item(query_item(int'(signed'(rand_coord())), int'(ln.start_y)));
			return;
		end
		lo = (ln.start_y < ln.end_y) ? ln.start_y : ln.end_y;
		hi = (ln.start_y < ln.end_y) ? ln.end_y : ln.start_y;
		py = lo + int'($urandom_range(0, 1000000) % (hi - lo));
		add_item(query_item(int'(ln.start_x) + int'($urandom_range(0, 40)) - 20, py));
	endtask

	task automatic drain();
		do @(posedge clk);
		while (item_q.size() > 0 || in_valid || crossing_q.size() > 0);
		repeat (20) @(posedge clk);
	endtask

	task automatic set_count(int v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_data <= v[10:0];
		scan_count <= v[10:0];
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic int written_prefix();
		for (int k = 0; k < TABLE_DEPTH; k++)
			if (!written[k])
				return k;
		return TABLE_DEPTH;
	endfunction

	initial begin
		int cnt;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed: empty scan from reset, then a small hand-made table
		add_item(query_item(0, 0));
		add_item(line_item(0, 10, -10, 10, 10, 16'd5, 16'd6));
		add_item(line_item(1, 10, 10, 10, -10, 16'd7, NO_SECTOR));
		add_item(line_item(2, -20, -5, -20, 5, NO_SECTOR, 16'd9));
		add_item(line_item(3, 0, 0, 100, 0, 16'd1, 16'd2));
		add_item(line_item(4, -32768, -32768, 32767, 32767, 16'd0, 16'd65534));
		add_item(line_item(5, 0, 0, 1, 10, 16'd11, 16'd12));
		add_item(line_item(6, 3, -1, 3, 1, NO_SECTOR, NO_SECTOR));
		add_item(line_item(7, -32768, 32767, 32767, -32768, 16'hffff, 16'h0));
		for (int k = 0; k < 8; k++)
			written[k] = 1;
		drain();
		set_count(8);
		add_item(query_item(0, 0));
		add_item(query_item(0, 1));   // exactly one tenth away from line 5
		add_item(query_item(10, 0));  // on the line itself
		add_item(query_item(-32768, -32768));
		add_item(query_item(32767, 32767));
		add_item(query_item(0, 5));
		add_item(query_item(11, 3));
		add_item(query_item(-30, 0));
		add_item(query_item(-32768, 32767));
		drain();
		set_count(2);
		add_item(query_item(0, 0));
		add_item(query_item(20, 9));
		drain();

		// random phases with varied scan lengths
		for (int ph = 0; ph < 13; ph++) begin
			case (ph)
				4: cnt = 0;
				7: cnt = 200;
				default: cnt = $urandom_range(1, 40);
			endcase
			for (int k = written_prefix(); k < cnt; k++)
				push_line(k);
			drain();
			set_count(cnt);
			if (ph == 5)
				rx_hold_req = 1'b1;
			for (int k = 0; k < 28; k++) begin
				if ($urandom_range(0, 9) < 6)
					push_query(cnt);
				else if ($urandom_range(0, 9) == 0)
					push_line($urandom_range(0, TABLE_DEPTH - 1));
				else
					push_line($urandom_range(0, cnt + 8));
			end
			drain();
		end

		repeat (40) @(posedge clk);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
